// ===== sv/heq_pkg.sv =====
// Shared types and constants for the histogram equalizer.
package heq_pkg;

	// Action codes carried in s_tuser.
	typedef enum logic [1:0] {
		ACT_COUNT    = 2'd0,
		ACT_EQUALIZE = 2'd1,
		ACT_READ     = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	localparam int MAX_PIXELS_DEF = 65536;
	localparam int BINS_DEF       = 256;

	localparam int PIX_W     = 8;   // grey pixel and bin_index width
	localparam int CNT_OUT_W = 17;  // count fields on the output
	localparam int QUO_W     = 8;   // mapped pixel width
	localparam int USER_W    = 2;
	localparam int IN_DATA_W = 16;  // pixel, bin_index
	localparam int OUT_DATA_W = 64; // mapped, count, cumulative, equalized + pad

endpackage

// ===== sv/histogram_equalizer.sv =====
// Histogram equalizer top level: control sequencer around three count RAMs.
//
// One item is handled at a time. A count transfer does a RAM read, then an
// increment and write back; when marked by tlast the cumulative table is
// then built by a sweep over bin_counts. An equalize transfer does a
// cumulative RAM read, runs the bit-per-cycle divider (8 quotient bits)
// computing floor(cum*255/total), then a read and write back of the
// equalized bin, then the result slot; before any table is built it
// returns 0. A read transfer returns one entry of each table; a bin_index
// at or past BINS reads as zero. A clear transfer starts a zeroing sweep
// over every entry of all RAMs, and the same sweep runs right after reset;
// s_tready stays low while it runs. Results sit in an output register, so
// the next input transfer is taken while a result still waits on m_tready.
// Counts saturate at MAX_PIXELS; count fields on the output are the low 17
// bits.
module histogram_equalizer
	import heq_pkg::*;
#(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int BINS       = BINS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pixel[7:0], bin_index[15:8]
	input  logic [USER_W-1:0]     s_tuser,  // action[1:0]
	input  logic                  s_tlast,  // last counted pixel of the frame
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // mapped_pixel[7:0], bin_count[24:8],
	                                        // bin_cumulative[41:25],
	                                        // equalized_count[58:42], zero[63:59]
);

	localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CW  = $clog2(MAX_PIXELS + 1);
	localparam int CXW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CNT, ST_BUILD, ST_EQ_RD, ST_DIV,
		ST_EQ_ISS, ST_EQ_WR, ST_RD, ST_OUT
	} state_t;

	function automatic logic [BW-1:0] bin_of(input logic [PIX_W-1:0] v);
		return (int'(v) >= BINS) ? BW'(BINS - 1) : BW'(v);
	endfunction

	function automatic logic [CNT_OUT_W-1:0] to_out(input logic [CW-1:0] v);
		logic [CXW-1:0] e;
		e = CXW'(v);
		return e[CNT_OUT_W-1:0];
	endfunction

	// input field split
	logic [PIX_W-1:0] in_pixel;
	logic [PIX_W-1:0] in_idx;
	action_t          in_act;
	assign in_pixel = s_tdata[PIX_W-1:0];
	assign in_idx   = s_tdata[2*PIX_W-1:PIX_W];
	assign in_act   = action_t'(s_tuser);

	state_t           state_q;
	logic [BW:0]      sweep_q;
	logic [BW-1:0]    bin_q;       // bin of the counted / equalized pixel
	logic             idx_ok_q;
	logic             last_q;
	logic [CW-1:0]    total_q;
	logic             ready_q;     // cumulative table built
	logic [CW-1:0]    run_q;
	logic             bld_v_s1;
	logic [BW-1:0]    bld_idx_s1;
	logic [QUO_W-1:0] mapped_q;
	logic [QUO_W-1:0] res_map_q;
	logic [CNT_OUT_W-1:0] res_cnt_q, res_cum_q, res_eq_q;
	logic             m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	// RAM ports
	logic          bc_we, cum_we, eq_we;
	logic [BW-1:0] bc_wa, cum_wa, eq_wa;
	logic [CW-1:0] bc_wd, cum_wd, eq_wd;
	logic [BW-1:0] bc_ra, cum_ra, eq_ra;
	logic [CW-1:0] bc_rd, cum_rd, eq_rd;

	logic [BW-1:0] in_addr;
	logic [BW-1:0] eq_bin;
	logic [CW-1:0] run_nxt;
	logic          total_ok;
	logic          div_start, div_done;
	logic [CW+7:0] div_num;
	logic [QUO_W-1:0] div_quo;
	logic          out_free;

	assign in_addr  = (in_act == ACT_READ) ? BW'(in_idx) : bin_of(in_pixel);
	assign eq_bin   = bin_of(mapped_q);
	assign run_nxt  = run_q + bc_rd;
	assign total_ok = total_q < CW'(MAX_PIXELS);
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// cum * 255 as a shift and subtract
	assign div_num   = {cum_rd, 8'd0} - (CW+8)'(cum_rd);
	assign div_start = (state_q == ST_EQ_RD) && (total_q != '0);

	always_comb begin
		bc_we  = 1'b0;  bc_wa  = sweep_q[BW-1:0];  bc_wd  = '0;
		cum_we = 1'b0;  cum_wa = sweep_q[BW-1:0];  cum_wd = '0;
		eq_we  = 1'b0;  eq_wa  = sweep_q[BW-1:0];  eq_wd  = '0;
		bc_ra  = in_addr;
		cum_ra = in_addr;
		eq_ra  = in_addr;
		unique case (state_q)
			ST_CLEAR: begin
				bc_we  = 1'b1;
				cum_we = 1'b1;
				eq_we  = 1'b1;
			end
			ST_CNT: begin
				bc_we = total_ok;
				bc_wa = bin_q;
				bc_wd = bc_rd + CW'(1);
			end
			ST_BUILD: begin
				bc_ra  = sweep_q[BW-1:0];
				cum_we = bld_v_s1;
				cum_wa = bld_idx_s1;
				cum_wd = run_nxt;
			end
			ST_EQ_ISS: begin
				eq_ra = eq_bin;
			end
			ST_EQ_WR: begin
				eq_we = eq_rd < CW'(MAX_PIXELS);
				eq_wa = eq_bin;
				eq_wd = eq_rd + CW'(1);
			end
			default: begin
			end
		endcase
	end

	heq_ram #(.DW(CW), .AW(BW), .DEPTH(BINS)) u_bc (
		.clk(clk), .we(bc_we), .waddr(bc_wa), .wdata(bc_wd),
		.raddr(bc_ra), .rdata(bc_rd)
	);

	heq_ram #(.DW(CW), .AW(BW), .DEPTH(BINS)) u_cum (
		.clk(clk), .we(cum_we), .waddr(cum_wa), .wdata(cum_wd),
		.raddr(cum_ra), .rdata(cum_rd)
	);

	heq_ram #(.DW(CW), .AW(BW), .DEPTH(BINS)) u_eq (
		.clk(clk), .we(eq_we), .waddr(eq_wa), .wdata(eq_wd),
		.raddr(eq_ra), .rdata(eq_rd)
	);

	heq_div #(.CW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(total_q), .done(div_done), .quo(div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			sweep_q   <= '0;
			total_q   <= '0;
			ready_q   <= 1'b0;
			bld_v_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// result slot: loaded from ST_OUT, emptied by a result transfer
			m_valid_q <= (state_q == ST_OUT && out_free) || (m_valid_q && !m_tready);
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == (BW+1)'(BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (in_act)
							ACT_COUNT:    state_q <= ST_CNT;
							ACT_EQUALIZE: state_q <= ready_q ? ST_EQ_RD : ST_OUT;
							ACT_READ:     state_q <= ST_RD;
							ACT_CLEAR: begin
								state_q <= ST_CLEAR;
								sweep_q <= '0;
								total_q <= '0;
								ready_q <= 1'b0;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CNT: begin
					if (total_ok) begin
						total_q <= total_q + CW'(1);
					end
					if (last_q) begin
						state_q  <= ST_BUILD;
						sweep_q  <= '0;
						bld_v_s1 <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BUILD: begin
					// issue reads of bin_counts, accumulate in the cycle after
					if (sweep_q < (BW+1)'(BINS)) begin
						sweep_q <= sweep_q + 1'b1;
					end
					bld_v_s1 <= sweep_q < (BW+1)'(BINS);
					if (bld_v_s1 && bld_idx_s1 == BW'(BINS - 1)) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_EQ_RD: begin
					state_q <= (total_q != '0) ? ST_DIV : ST_EQ_ISS;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EQ_ISS;
					end
				end
				ST_EQ_ISS: state_q <= ST_EQ_WR;
				ST_EQ_WR:  state_q <= ST_OUT;
				ST_RD:     state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			bin_q     <= bin_of(in_pixel);
			idx_ok_q  <= int'(in_idx) < BINS;
			last_q    <= s_tlast;
			mapped_q  <= '0;
			res_map_q <= '0;
			res_cnt_q <= '0;
			res_cum_q <= '0;
			res_eq_q  <= '0;
		end
		if (state_q == ST_CNT) begin
			run_q <= '0;
		end else if (state_q == ST_BUILD && bld_v_s1) begin
			run_q <= run_nxt;
		end
		bld_idx_s1 <= sweep_q[BW-1:0];
		if (state_q == ST_DIV && div_done) begin
			mapped_q <= div_quo;
		end
		if (state_q == ST_EQ_WR) begin
			res_map_q <= mapped_q;
		end
		if (state_q == ST_RD && idx_ok_q) begin
			res_cnt_q <= to_out(bc_rd);
			res_cum_q <= to_out(cum_rd);
			res_eq_q  <= to_out(eq_rd);
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= OUT_DATA_W'({res_eq_q, res_cum_q, res_cnt_q, res_map_q});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== sv/heq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module heq_ram #(
	parameter int DW    = 17,
	parameter int AW    = 8,
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/heq_div.sv =====
// Restoring divider producing an 8-bit quotient, one bit per cycle.
module heq_div
	import heq_pkg::*;
#(
	parameter int CW = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW+7:0]    num,
	input  logic [CW-1:0]    den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int NW = CW + QUO_W;

	logic          busy_q;
	logic          done_q;
	logic [2:0]    cnt_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient < 256 since numerator < 256 * divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << 7;
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/heq_checker.sv =====
// Port-level checker for the histogram equalizer, bound to the top level.
module heq_checker
	import heq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [USER_W-1:0]     s_tuser,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// pad bits above the last field stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:59] == '0)
		else $error("nonzero pad bits");

	// a nonzero mapped pixel comes from equalize, which carries no counts
	a_eq_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[58:8] == '0)
		else $error("equalize result with count fields");

	// clear starts the zeroing sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_CLEAR |=> !s_tready)
		else $error("input taken during clear sweep");

	// count does a read-modify-write before the next item
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_COUNT |=> !s_tready)
		else $error("input taken during count update");

endmodule

bind histogram_equalizer heq_checker u_heq_checker (.*);

// ===== sim/tb_histogram_equalizer.sv =====
// Self-checking testbench for the histogram equalizer stream block.
`timescale 1ns / 1ps

module tb_histogram_equalizer;
	import heq_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int DENSE_PIXELS   = 64;

	typedef struct packed {
		logic [7:0]  mapped;
		logic [16:0] count;
		logic [16:0] cumulative;
		logic [16:0] equalized;
	} heq_result_t;

	// Scoreboard: owns its own copy of the tables and the queue of pending results.
	class heq_scoreboard;
		logic [16:0] hist[BINS_DEF];
		logic [16:0] cum[BINS_DEF];
		logic [16:0] eq_hist[BINS_DEF];
		int unsigned total;
		bit          ready;
		heq_result_t pending_q[$];
		int          errors;

		function new();
			clear_tables();
			errors = 0;
		endfunction

		function void clear_tables();
			for (int k = 0; k < BINS_DEF; k++) begin
				hist[k] = '0;
				cum[k] = '0;
				eq_hist[k] = '0;
			end
			total = 0;
			ready = 0;
		endfunction

		function void note_transfer(action_t act, logic [7:0] pix, logic [7:0] idx, logic lst);
			heq_result_t r;
			longint unsigned q;
			logic [16:0] run;
			r = '0;
			case (act)
				ACT_COUNT: begin
					if (total < MAX_PIXELS_DEF) begin
						hist[pix] = hist[pix] + 17'd1;
						total++;
					end
					if (lst) begin
						run = '0;
						for (int k = 0; k < BINS_DEF; k++) begin
							run = run + hist[k];
							cum[k] = run;
						end
						ready = 1;
					end
				end
				ACT_EQUALIZE: begin
					if (ready) begin
						if (total != 0) begin
							q = (longint'(cum[pix]) * 255) / total;
							r.mapped = (q > 255) ? 8'd255 : q[7:0];
						end
						if (eq_hist[r.mapped] < MAX_PIXELS_DEF)
							eq_hist[r.mapped] = eq_hist[r.mapped] + 17'd1;
					end
					pending_q.push_back(r);
				end
				ACT_READ: begin
					r.count = hist[idx];
					r.cumulative = cum[idx];
					r.equalized = eq_hist[idx];
					pending_q.push_back(r);
				end
				ACT_CLEAR: clear_tables();
			endcase
		endfunction

		function void check_transfer(logic [OUT_DATA_W-1:0] data);
			heq_result_t exp_r;
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer: %h", data);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (data[7:0] !== exp_r.mapped) begin
				$error("mapped_pixel: expected %0d, got %0d", exp_r.mapped, data[7:0]);
				errors++;
			end
			if (data[24:8] !== exp_r.count) begin
				$error("bin_count: expected %0d, got %0d", exp_r.count, data[24:8]);
				errors++;
			end
			if (data[41:25] !== exp_r.cumulative) begin
				$error("bin_cumulative: expected %0d, got %0d", exp_r.cumulative,
					data[41:25]);
				errors++;
			end
			if (data[58:42] !== exp_r.equalized) begin
				$error("equalized_count: expected %0d, got %0d", exp_r.equalized,
					data[58:42]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [USER_W-1:0]     s_tuser = '0;
	logic                  s_tlast = 0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;

	heq_scoreboard sb = new();
	int  burst_left = 0;
	bit  gaps_on = 1;
	bit  built_once = 0;   // cumulative table never read before its first build
	bit  drained_mid = 0;
	int  idle_cycles = 0;
	int  rx_mode = 0;
	int  rx_left = 0;

	histogram_equalizer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// Monitors: input transfers feed the predictor, result transfers get checked.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_transfer(action_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tlast);
		if (m_tvalid && m_tready)
			sb.check_transfer(m_tdata);
	end

	// Receiver stall pattern: stretches of always-ready, random, sparse and mostly-ready readiness.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(action_t act, logic [7:0] pix, logic [7:0] idx, logic lst);
		if (burst_left == 0) begin
			if (gaps_on && $urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {idx, pix};
		s_tlast  <= lst;
		if (act == ACT_COUNT && lst)
			built_once = 1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// One frame: a run of counts ended by tlast, then equalizes, reads and extra counts.
	task automatic random_frame();
		int n_px;
		int n_use;
		logic [7:0] base;
		n_px = $urandom_range(1, 40);
		base = 8'($urandom);
		for (int k = 0; k < n_px; k++)
			send_item(ACT_COUNT, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
				8'(base + 8'($urandom_range(0, 15))), 8'($urandom), k == n_px - 1);
		n_use = $urandom_range(1, 20);
		for (int k = 0; k < n_use; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_item(ACT_EQUALIZE, 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)));
				5, 6, 7: send_item(ACT_READ, 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)));
				// counting after the build keeps the table but changes the total
				default: send_item(ACT_COUNT, 8'($urandom), 8'($urandom), 1'b0);
			endcase
		end
	endtask

	int items_sent;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: equalize with no table, extremes, clear, counting after build.
		send_item(ACT_EQUALIZE, 8'd0, 8'd0, 1'b0);
		send_item(ACT_EQUALIZE, 8'd255, 8'd255, 1'b1);
		send_item(ACT_COUNT, 8'd0, 8'd255, 1'b0);
		send_item(ACT_COUNT, 8'd255, 8'd0, 1'b0);
		send_item(ACT_COUNT, 8'h5A, 8'hA5, 1'b1);
		send_item(ACT_READ, 8'hFF, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd255, 1'b1);
		send_item(ACT_READ, 8'h0F, 8'h5A, 1'b0);
		send_item(ACT_EQUALIZE, 8'd0, 8'd0, 1'b0);
		send_item(ACT_EQUALIZE, 8'd255, 8'd0, 1'b0);
		send_item(ACT_EQUALIZE, 8'hA5, 8'd0, 1'b0);
		send_item(ACT_COUNT, 8'hF0, 8'hFF, 1'b0);
		send_item(ACT_EQUALIZE, 8'hFF, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd255, 1'b0);
		send_item(ACT_CLEAR, 8'hFF, 8'hFF, 1'b1);
		send_item(ACT_EQUALIZE, 8'h80, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'h80, 1'b0);
		send_item(ACT_COUNT, 8'h33, 8'd0, 1'b1);
		send_item(ACT_EQUALIZE, 8'h33, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'h33, 1'b0);
		send_item(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
		send_item(ACT_COUNT, 8'd1, 8'd0, 1'b1);

		// Dense frame: back-to-back counts, then build and inspect.
		gaps_on = 0;
		for (int k = 0; k < DENSE_PIXELS; k++)
			send_item(ACT_COUNT, 8'($urandom), 8'($urandom), k == DENSE_PIXELS - 1);
		for (int k = 0; k < 8; k++) begin
			send_item(ACT_READ, 8'd0, (k == 0) ? 8'd255 : 8'($urandom), 1'b0);
			send_item(ACT_EQUALIZE, (k == 0) ? 8'd255 : 8'($urandom), 8'd0, 1'b0);
		end
		send_item(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
		gaps_on = 1;

		// Random: mostly well-formed frames, some noise and stray clears.
		items_sent = 0;
		while (items_sent < 700) begin
			if (items_sent > 350 && !drained_mid) begin
				wait_drained();
				drained_mid = 1;
			end
			case ($urandom_range(0, 9))
				0: begin
					send_item(ACT_CLEAR, 8'($urandom), 8'($urandom),
						1'($urandom_range(0, 1)));
					items_sent++;
				end
				1: begin
					if (built_once)
						send_item(ACT_READ, 8'($urandom), 8'($urandom),
							1'($urandom_range(0, 1)));
					else
						send_item(ACT_EQUALIZE, 8'($urandom), 8'($urandom),
							1'($urandom_range(0, 1)));
					items_sent++;
				end
				default: begin
					random_frame();
					items_sent += 30;
				end
			endcase
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
